@@ rtl/top_k_score_list_macros.svh @@
// Assertion macros used by the datapath RTL file of the top-k score list.
`ifndef TOP_K_SCORE_LIST_MACROS_SVH
`define TOP_K_SCORE_LIST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TKSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tksl_pkg.sv @@
`default_nettype none
package tksl_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
	localparam int LIMIT_W = 5;
	localparam int RANK_W = 4;
	localparam int STATUS_W = 3;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd4;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LIST_ENTRY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY_LIST = 3'd4;

	typedef struct packed {
		logic operation;
		logic [31:0] cand_tag;
		logic signed [31:0] cand_score;
		logic cand_spliced;
	} cand_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [RANK_W-1:0] rank;
		logic [31:0] entry_tag_out;
		logic signed [31:0] entry_score_out;
		logic entry_spliced_out;
		logic [31:0] unspliced_total;
		logic [31:0] spliced_total;
		logic last;
	} res_item_t;

	typedef struct packed {
		logic [31:0] tag;
		logic signed [31:0] score;
		logic spliced;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap;
		logic ins;
		logic fl;
	} tksl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic fl_last;
	} tksl_sts_t;

endpackage
`default_nettype wire

@@ rtl/tksl_dp.sv @@
`default_nettype none
`include "top_k_score_list_macros.svh"
module tksl_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire tksl_pkg::cand_item_t cand,
	input wire logic cfg_valid,
	input wire logic [tksl_pkg::LIMIT_W-1:0] cfg_data,
	input wire tksl_pkg::tksl_cmd_t cmd,
	output tksl_pkg::tksl_sts_t sts,
	output logic res_valid,
	input wire logic res_stall,
	output tksl_pkg::res_item_t res
);

	tksl_pkg::cand_item_t cand_q;
	tksl_pkg::entry_t slot_q [tksl_pkg::MAX_ENTRIES];
	tksl_pkg::entry_t cand_entry;
	tksl_pkg::res_item_t ins_res;
	tksl_pkg::res_item_t fl_res;
	tksl_pkg::res_item_t res_q;
	logic res_valid_q;
	logic [tksl_pkg::FILL_W-1:0] fill_q;
	logic [tksl_pkg::LIMIT_W-1:0] limit_q;
	logic [tksl_pkg::IDX_W-1:0] frank_q;
	logic [31:0] unspl_q;
	logic [31:0] spl_q;
	logic [31:0] unspl_nxt;
	logic [31:0] spl_nxt;
	logic [tksl_pkg::FILL_W-1:0] lim;
	logic [tksl_pkg::MAX_ENTRIES-1:0] dup;
	logic [tksl_pkg::MAX_ENTRIES-1:0] abv;
	logic found;
	logic is_dup;
	logic [tksl_pkg::IDX_W-1:0] pos;
	logic [tksl_pkg::FILL_W-1:0] fill_inc;
	logic [tksl_pkg::FILL_W-1:0] fill_ins;
	logic can_app;
	logic [tksl_pkg::IDX_W-1:0] app_idx;
	logic do_shift;
	logic do_app;
	logic fl_empty;
	logic out_free;

	assign cand_entry = '{tag: cand_q.cand_tag, score: cand_q.cand_score,
		spliced: cand_q.cand_spliced};

	// A limit of zero behaves as one; a limit above the list size behaves as the list size.
	always_comb begin
		if (limit_q == '0) begin
			lim = tksl_pkg::FILL_W'(1);
		end else if (tksl_pkg::FILL_W'(limit_q) > tksl_pkg::FILL_W'(tksl_pkg::MAX_ENTRIES)) begin
			lim = tksl_pkg::FILL_W'(tksl_pkg::MAX_ENTRIES);
		end else begin
			lim = tksl_pkg::FILL_W'(limit_q);
		end
	end

	// Every live slot is checked for a matching tag and a lower score in parallel.
	always_comb begin
		for (int i = 0; i < tksl_pkg::MAX_ENTRIES; i++) begin
			dup[i] = (tksl_pkg::FILL_W'(i) < fill_q) && (slot_q[i].tag == cand_q.cand_tag);
			abv[i] = (tksl_pkg::FILL_W'(i) < fill_q)
				&& ($signed(cand_q.cand_score) > $signed(slot_q[i].score));
		end
	end

	// The first slot that matches or scores lower decides the outcome.
	always_comb begin
		found = 1'b0;
		pos = '0;
		for (int i = tksl_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
			if (dup[i] || abv[i]) begin
				found = 1'b1;
				pos = tksl_pkg::IDX_W'(i);
			end
		end
	end

	assign is_dup = found && dup[pos];
	assign fill_inc = fill_q + tksl_pkg::FILL_W'(1);
	assign fill_ins = (fill_inc > lim) ? fill_q : fill_inc;
	assign can_app = fill_q < lim;
	assign app_idx = fill_q[tksl_pkg::IDX_W-1:0];
	assign do_shift = cmd.ins && found && !is_dup;
	assign do_app = cmd.ins && !found && can_app;
	assign fl_empty = (fill_q == '0);

	assign spl_nxt = (cand_q.cand_spliced && (spl_q != '1)) ? spl_q + 32'd1 : spl_q;
	assign unspl_nxt = (!cand_q.cand_spliced && (unspl_q != '1)) ? unspl_q + 32'd1 : unspl_q;

	always_comb begin
		ins_res.entry_tag_out = cand_q.cand_tag;
		ins_res.entry_score_out = cand_q.cand_score;
		ins_res.entry_spliced_out = cand_q.cand_spliced;
		ins_res.unspliced_total = unspl_nxt;
		ins_res.spliced_total = spl_nxt;
		ins_res.last = 1'b1;
		if (is_dup) begin
			ins_res.status = tksl_pkg::ST_DUPLICATE;
			ins_res.rank = tksl_pkg::RANK_W'(pos);
		end else if (found) begin
			ins_res.status = tksl_pkg::ST_INSERTED;
			ins_res.rank = tksl_pkg::RANK_W'(pos);
		end else if (can_app) begin
			ins_res.status = tksl_pkg::ST_INSERTED;
			ins_res.rank = tksl_pkg::RANK_W'(app_idx);
		end else begin
			ins_res.status = tksl_pkg::ST_REJECTED;
			ins_res.rank = '0;
		end
	end

	// A non-empty flush reports the head slot, since the list moves up one place per result.
	always_comb begin
		fl_res.unspliced_total = unspl_q;
		fl_res.spliced_total = spl_q;
		if (fl_empty) begin
			fl_res.status = tksl_pkg::ST_EMPTY_LIST;
			fl_res.rank = '0;
			fl_res.entry_tag_out = '0;
			fl_res.entry_score_out = '0;
			fl_res.entry_spliced_out = 1'b0;
			fl_res.last = 1'b1;
		end else begin
			fl_res.status = tksl_pkg::ST_LIST_ENTRY;
			fl_res.rank = tksl_pkg::RANK_W'(frank_q);
			fl_res.entry_tag_out = slot_q[0].tag;
			fl_res.entry_score_out = slot_q[0].score;
			fl_res.entry_spliced_out = slot_q[0].spliced;
			fl_res.last = sts.fl_last;
		end
	end

	assign out_free = !res_valid_q || !res_stall;
	assign sts.out_free = out_free;
	assign sts.fl_last = fl_empty
		|| ((tksl_pkg::FILL_W'(frank_q) + tksl_pkg::FILL_W'(1)) == fill_q);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cand_q <= cand;
		end
	end

	for (genvar g = 0; g < tksl_pkg::MAX_ENTRIES; g++) begin : g_slot
		always_ff @(posedge clk) begin
			if (do_shift && (pos == tksl_pkg::IDX_W'(g))) begin
				slot_q[g] <= cand_entry;
			end else if (do_app && (app_idx == tksl_pkg::IDX_W'(g))) begin
				slot_q[g] <= cand_entry;
			end else if (g > 0 && do_shift && (pos < tksl_pkg::IDX_W'(g))) begin
				slot_q[g] <= slot_q[(g > 0) ? g - 1 : 0];
			end else if (g < tksl_pkg::MAX_ENTRIES - 1 && cmd.fl && !fl_empty) begin
				slot_q[g] <= slot_q[(g < tksl_pkg::MAX_ENTRIES - 1) ? g + 1 : g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			unspl_q <= '0;
			spl_q <= '0;
			frank_q <= '0;
			limit_q <= tksl_pkg::LIMIT_RESET;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.ins) begin
				unspl_q <= unspl_nxt;
				spl_q <= spl_nxt;
				if (do_shift) begin
					fill_q <= fill_ins;
				end else if (do_app) begin
					fill_q <= fill_inc;
				end
			end else if (cmd.fl && !fl_empty) begin
				if (sts.fl_last) begin
					fill_q <= '0;
					unspl_q <= '0;
					spl_q <= '0;
					frank_q <= '0;
				end else begin
					frank_q <= frank_q + tksl_pkg::IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.ins || cmd.fl) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			res_q <= ins_res;
		end else if (cmd.fl) begin
			res_q <= fl_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`TKSL_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1,
		fill_q <= tksl_pkg::FILL_W'(tksl_pkg::MAX_ENTRIES), "list fill exceeds list size")
	`TKSL_ASSERT_NOW(a_load_free, clk, arst_n, cmd.ins || cmd.fl, out_free,
		"result loaded over one not yet taken")
	`TKSL_ASSERT_NEXT(a_flush_clears, clk, arst_n, cmd.fl && !fl_empty && sts.fl_last,
		fill_q == '0 && unspl_q == '0 && spl_q == '0, "final flush result left state behind")

endmodule
`default_nettype wire

@@ rtl/tksl_ctrl.sv @@
`default_nettype none
module tksl_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cand_valid,
	input wire logic cand_op,
	output logic cand_stall,
	input wire tksl_pkg::tksl_sts_t sts,
	output tksl_pkg::tksl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_INSERT = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign cand_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cand_valid) begin
					cmd.cap = 1'b1;
					state_nxt = (cand_op == tksl_pkg::OP_FLUSH) ? S_FLUSH : S_INSERT;
				end
			end
			S_INSERT: begin
				if (sts.out_free) begin
					cmd.ins = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.fl = 1'b1;
					if (sts.fl_last) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

@@ rtl/top_k_score_list.sv @@
// Top-k score list: keeps the best candidates seen so far, best first.
// Input channel (cand_valid, cand_stall, cand) carries one transaction per
// candidate: an insert, or a flush that reports and clears the whole list.
// Output channel (res_valid, res_stall, res) returns one transaction per
// insert, and one per list entry for a flush (a single one if the list is
// empty); the final result of each input has last set.
// An insert is captured on acceptance, then evaluated against all slots in
// parallel in the insert state once the output register is free; its result
// is registered then and the block returns to idle to accept the next input.
// A flush is accepted, then reports one entry per cycle while the output
// register is free, the rate being set by that single output register.
// A waiting result does not block acceptance of the next input; when the
// receiver holds res_stall, the evaluation waits until the output register
// is taken, and the input side stalls meanwhile.
// The user writes the list limit via cfg_valid and cfg_data only while the
// block is idle (not enforced); cfg_ready is always high. Reset clears both
// counters, sets the limit to four and empties the list but not its slots.
`default_nettype none
module top_k_score_list (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cand_valid,
	output logic cand_stall,
	input wire tksl_pkg::cand_item_t cand,
	output logic res_valid,
	input wire logic res_stall,
	output tksl_pkg::res_item_t res,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [tksl_pkg::LIMIT_W-1:0] cfg_data
);

	tksl_pkg::tksl_cmd_t cmd;
	tksl_pkg::tksl_sts_t sts;

	// The limit register can take a write in any cycle.
	assign cfg_ready = 1'b1;

	tksl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cand_valid(cand_valid),
		.cand_op(cand.operation),
		.cand_stall(cand_stall),
		.sts(sts),
		.cmd(cmd)
	);

	tksl_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cand(cand),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	// Clock, reset and the signals of the block.
	logic clk;
	logic arst_n = 1'b0;
	logic cand_valid = 1'b0;
	logic cand_stall;
	tksl_pkg::cand_item_t cand = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	tksl_pkg::res_item_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tksl_pkg::LIMIT_W-1:0] cfg_data = '0;

	top_k_score_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.cand_valid(cand_valid),
		.cand_stall(cand_stall),
		.cand(cand),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the list, the two counters and the limit register. The list
	// and counters are updated once for every accepted input transaction.
	logic [31:0] shadow_tag [tksl_pkg::MAX_ENTRIES];
	logic signed [31:0] shadow_score [tksl_pkg::MAX_ENTRIES];
	logic shadow_spl [tksl_pkg::MAX_ENTRIES];
	int shadow_fill = 0;
	logic [31:0] shadow_unspliced = '0;
	logic [31:0] shadow_spliced = '0;
	logic [tksl_pkg::LIMIT_W-1:0] shadow_limit = tksl_pkg::LIMIT_RESET;

	// Results that the shadow list says must still come out, oldest first.
	tksl_pkg::res_item_t awaited_results [$];

	int error_count = 0;
	int results_seen = 0;

	// Sender burst state: number of further transactions before the next gap.
	int burst_left = 0;

	// Receiver stall pattern state.
	int stall_mode = 0;
	int stall_mode_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(10_000_000);
		$display("top_k_score_list: mismatch");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		error_count++;
		if (error_count <= 100)
			$display("[%0t] result %0d %s: expected %0h, got %0h", $realtime,
				results_seen, what, want, got);
	endtask

	// Appends one result to the tail of the awaited queue.
	function automatic void await_result(input tksl_pkg::res_item_t r);
		awaited_results = {awaited_results, r};
	endfunction

	// A result carries the counters after an insert's count, before a flush's clear.
	function automatic tksl_pkg::res_item_t make_result(
			input logic [tksl_pkg::STATUS_W-1:0] st,
			input int rk, input logic [31:0] tg, input logic [31:0] sc,
			input logic sp, input logic lst);
		tksl_pkg::res_item_t r;
		r.status = st;
		r.rank = rk[tksl_pkg::RANK_W-1:0];
		r.entry_tag_out = tg;
		r.entry_score_out = sc;
		r.entry_spliced_out = sp;
		r.unspliced_total = shadow_unspliced;
		r.spliced_total = shadow_spliced;
		r.last = lst;
		return r;
	endfunction

	function automatic void store_slot(input int idx, input tksl_pkg::cand_item_t c);
		shadow_tag[idx] = c.cand_tag;
		shadow_score[idx] = c.cand_score;
		shadow_spl[idx] = c.cand_spliced;
	endfunction

	// Applies one accepted transaction to the shadow list and queues the
	// results it must produce.
	function automatic void update_shadow_list(input tksl_pkg::cand_item_t c);
		int i;
		int pos;
		int lim;
		int grown;
		bit hit;
		if (c.operation == tksl_pkg::OP_FLUSH) begin
			// An empty list reports once and keeps its counters.
			if (shadow_fill == 0) begin
				await_result(make_result(tksl_pkg::ST_EMPTY_LIST, 0, '0, '0,
					1'b0, 1'b1));
				return;
			end
			for (i = 0; i < shadow_fill; i++)
				await_result(make_result(tksl_pkg::ST_LIST_ENTRY, i,
					shadow_tag[i], shadow_score[i], shadow_spl[i],
					i == shadow_fill - 1));
			shadow_fill = 0;
			shadow_unspliced = '0;
			shadow_spliced = '0;
			return;
		end
		// Every insert is counted, duplicates and rejects included.
		if (c.cand_spliced) begin
			if (shadow_spliced != '1)
				shadow_spliced++;
		end else begin
			if (shadow_unspliced != '1)
				shadow_unspliced++;
		end
		if (shadow_fill == 0) begin
			store_slot(0, c);
			shadow_fill = 1;
			await_result(make_result(tksl_pkg::ST_INSERTED, 0, c.cand_tag,
				c.cand_score, c.cand_spliced, 1'b1));
			return;
		end
		lim = shadow_limit;
		if (lim == 0)
			lim = 1;
		if (lim > tksl_pkg::MAX_ENTRIES)
			lim = tksl_pkg::MAX_ENTRIES;
		hit = 1'b0;
		pos = 0;
		// The tag of each position is checked before its score, so the entry
		// at the insertion point also counts for duplicates.
		for (i = 0; i < shadow_fill; i++) begin
			if (shadow_tag[i] == c.cand_tag) begin
				await_result(make_result(tksl_pkg::ST_DUPLICATE, i, c.cand_tag,
					c.cand_score, c.cand_spliced, 1'b1));
				return;
			end
			if ($signed(c.cand_score) > $signed(shadow_score[i])) begin
				pos = i;
				hit = 1'b1;
				break;
			end
		end
		if (hit) begin
			// Grow only while under the limit; otherwise one tail entry drops.
			grown = shadow_fill + 1;
			if (grown > lim)
				grown = shadow_fill;
			for (i = grown - 1; i > pos; i--) begin
				shadow_tag[i] = shadow_tag[i-1];
				shadow_score[i] = shadow_score[i-1];
				shadow_spl[i] = shadow_spl[i-1];
			end
			store_slot(pos, c);
			shadow_fill = grown;
			await_result(make_result(tksl_pkg::ST_INSERTED, pos, c.cand_tag,
				c.cand_score, c.cand_spliced, 1'b1));
		end else if (shadow_fill < lim) begin
			store_slot(shadow_fill, c);
			await_result(make_result(tksl_pkg::ST_INSERTED, shadow_fill,
				c.cand_tag, c.cand_score, c.cand_spliced, 1'b1));
			shadow_fill++;
		end else begin
			await_result(make_result(tksl_pkg::ST_REJECTED, 0, c.cand_tag,
				c.cand_score, c.cand_spliced, 1'b1));
		end
	endfunction

	// Offers one transaction and holds it until accepted. The sender works in
	// bursts; when a burst runs out, valid drops for a random gap. Valid stays
	// high across back-to-back transactions, so it is never lowered and raised
	// in the same step.
	task automatic offer_candidate(input tksl_pkg::cand_item_t c);
		cand <= c;
		cand_valid <= 1'b1;
		do
			@(posedge clk);
		while (cand_stall);
		update_shadow_list(c);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cand_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) :
				$urandom_range(0, 12);
		end
	endtask

	task automatic insert_cand(input logic [31:0] tg, input logic [31:0] sc,
			input logic sp);
		tksl_pkg::cand_item_t c;
		c.operation = tksl_pkg::OP_INSERT;
		c.cand_tag = tg;
		c.cand_score = sc;
		c.cand_spliced = sp;
		offer_candidate(c);
	endtask

	task automatic flush_list();
		tksl_pkg::cand_item_t c;
		c.operation = tksl_pkg::OP_FLUSH;
		c.cand_tag = $urandom;
		c.cand_score = $urandom;
		c.cand_spliced = $urandom_range(0, 1);
		offer_candidate(c);
	endtask

	// Stops sending and waits until every awaited result has come out, then
	// lets the block settle after its last result.
	task automatic wait_quiet();
		if (cand_valid)
			cand_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// The limit is only written while the block is idle.
	task automatic write_list_limit(input logic [tksl_pkg::LIMIT_W-1:0] value);
		wait_quiet();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_limit = value;
		@(posedge clk);
	endtask

	// Receiver: the stall pattern switches now and then between no stall,
	// light random stall, heavy random stall and long stall runs.
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_mode_left = $urandom_range(16, 160);
		end else begin
			stall_mode_left--;
		end
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= ($urandom_range(0, 9) < 6);
			default: res_stall <= ((stall_mode_left % 16) < 11);
		endcase
	end

	// Each result transaction is checked field by field against the oldest
	// awaited result.
	always @(posedge clk) begin
		tksl_pkg::res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("unexpected result, status", '0, res.status);
			end else begin
				want = awaited_results.pop_front();
				if (res.status !== want.status)
					flag_mismatch("status", want.status, res.status);
				if (res.rank !== want.rank)
					flag_mismatch("rank", want.rank, res.rank);
				if (res.entry_tag_out !== want.entry_tag_out)
					flag_mismatch("entry_tag_out", want.entry_tag_out, res.entry_tag_out);
				if (res.entry_score_out !== want.entry_score_out)
					flag_mismatch("entry_score_out", want.entry_score_out,
						res.entry_score_out);
				if (res.entry_spliced_out !== want.entry_spliced_out)
					flag_mismatch("entry_spliced_out", want.entry_spliced_out,
						res.entry_spliced_out);
				if (res.unspliced_total !== want.unspliced_total)
					flag_mismatch("unspliced_total", want.unspliced_total,
						res.unspliced_total);
				if (res.spliced_total !== want.spliced_total)
					flag_mismatch("spliced_total", want.spliced_total, res.spliced_total);
				if (res.last !== want.last)
					flag_mismatch("last", want.last, res.last);
			end
			results_seen++;
		end
	end

	// Reset limit of four: empty flush, extreme tags and scores, ties going
	// behind equal scores, a duplicate at the insertion point, a reject on a
	// full list, a tail entry falling off, and a full flush.
	task automatic test_basic_list();
		flush_list();
		insert_cand(32'h0000_0000, 32'h0000_0000, 1'b0);
		insert_cand(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		insert_cand(32'h0000_0003, 32'h8000_0000, 1'b0);
		insert_cand(32'h0000_0005, 32'h0000_0000, 1'b1);
		insert_cand(32'h0000_0000, 32'h0000_0005, 1'b1);
		insert_cand(32'h0000_0009, 32'h8000_0000, 1'b0);
		insert_cand(32'h0000_0003, 32'h0000_0001, 1'b0);
		insert_cand(32'h0000_0005, 32'h7FFF_FFFF, 1'b1);
		flush_list();
	endtask

	// A limit of zero behaves as a limit of one.
	task automatic test_zero_limit();
		write_list_limit(5'd0);
		insert_cand(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		insert_cand(32'h0000_0002, 32'h0000_0064, 1'b1);
		insert_cand(32'h0000_0003, 32'h0000_0064, 1'b0);
		flush_list();
	endtask

	// Lowering the limit below the fill: an insert drops only one tail entry
	// and nothing is appended while the fill is at or above the limit.
	task automatic test_lowered_limit();
		int i;
		write_list_limit(5'd16);
		for (i = 0; i < 6; i++)
			insert_cand(32'd10 + i, 32'd60 - 32'd10 * i, i[0]);
		write_list_limit(5'd2);
		insert_cand(32'd20, 32'd55, 1'b1);
		insert_cand(32'd21, 32'd5, 1'b0);
		flush_list();
	endtask

	// Random candidate: mostly inserts, a few flushes. Tags sometimes come
	// from a small pool so duplicates happen; scores sometimes cluster near
	// zero so ties happen, and sometimes sit at the extremes.
	function automatic tksl_pkg::cand_item_t random_candidate();
		tksl_pkg::cand_item_t c;
		int pick;
		c.operation = ($urandom_range(0, 13) == 0) ? tksl_pkg::OP_FLUSH :
			tksl_pkg::OP_INSERT;
		c.cand_tag = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 15)) :
			$urandom;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			c.cand_score = $urandom;
		end else if (pick < 8) begin
			c.cand_score = $urandom_range(0, 6) - 3;
		end else begin
			case ($urandom_range(0, 3))
				0: c.cand_score = 32'h7FFF_FFFF;
				1: c.cand_score = 32'h8000_0000;
				2: c.cand_score = 32'h0000_0000;
				default: c.cand_score = 32'hFFFF_FFFF;
			endcase
		end
		c.cand_spliced = $urandom_range(0, 1);
		return c;
	endfunction

	// Random traffic in phases with different limits, the extremes among
	// them. Each limit write first waits for the block to drain.
	task automatic test_random_traffic();
		logic [tksl_pkg::LIMIT_W-1:0] phase_limit [6];
		int p;
		int n;
		phase_limit[0] = 5'd16;
		phase_limit[1] = 5'd31;
		phase_limit[2] = 5'd1;
		phase_limit[3] = 5'($urandom_range(0, 31));
		phase_limit[4] = 5'd0;
		phase_limit[5] = 5'($urandom_range(2, 8));
		for (p = 0; p < 6; p++) begin
			write_list_limit(phase_limit[p]);
			for (n = 0; n < 80; n++)
				offer_candidate(random_candidate());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_list();
		test_zero_limit();
		test_lowered_limit();
		test_random_traffic();

		wait_quiet();
		if (awaited_results.size() != 0)
			flag_mismatch("results never seen", '0, awaited_results.size());
		if (error_count == 0) begin
			$display("top_k_score_list: match");
		end else begin
			$display("top_k_score_list: mismatch");
		end
		$finish;
	end

endmodule
